>>> sv/spq_pkg.sv
// Shared types and constants of the sorted priority task queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int unsigned DEFAULT_DEPTH = 16;
  localparam int unsigned ID_W          = 32;
  localparam int unsigned PRIO_W        = 32;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned COUNT_W       = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_APPLY,
    S_REPLY
  } state_t;

  // One queue slot as it moves between neighbouring cells.
  typedef struct packed {
    logic                     valid;
    logic signed [ID_W-1:0]   id;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic capture;
    logic apply;
    op_t  op;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> sv/sorted_priority_task_queue_unit.sv
// Top level of the sorted priority task queue: command sequencer and row of cells.
//
// Usage: a request (operation, task_id, task_priority) is taken at a rising edge
// where start is high and busy is low. An insert places the task behind every
// held task of greater or equal priority; a delete removes the first task from
// the head whose id matches. Every request yields exactly one result: done is
// high for one cycle with status, entry_count, head_id and head_priority.
// The receiver cannot stall; done is not held beyond that cycle.
// Steps: the sequencer moves from idle through compare, where every cell compares
// its entry, apply, where all cells shift in parallel, and reply, where done is
// high, then back to idle. busy stays high until the sequencer is back in idle,
// so a new request is taken only after the last one has been answered.
// Each cell handles one slot, so the time does not grow with DEPTH.
// Reset (rst, synchronous) empties the queue at once: no clearing pass is needed,
// since only the valid flags of the cells are cleared.
// head_id and head_priority read zero while the queue is empty.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_task_queue_unit #(
  parameter int unsigned DEPTH = spq_pkg::DEFAULT_DEPTH
) (
  input  wire  logic                                clk,
  input  wire  logic                                rst,
  input  wire  logic                                start,
  output logic                                      busy,
  input  wire  logic                                operation,
  input  wire  logic signed [spq_pkg::ID_W-1:0]     task_id,
  input  wire  logic signed [spq_pkg::PRIO_W-1:0]   task_priority,
  output logic                                      done,
  output logic [spq_pkg::STATUS_W-1:0]              status,
  output logic [spq_pkg::COUNT_W-1:0]               entry_count,
  output logic signed [spq_pkg::ID_W-1:0]           head_id,
  output logic signed [spq_pkg::PRIO_W-1:0]         head_priority
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  spq_pkg::state_t    state, state_next;
  spq_pkg::entry_t    cmd;
  spq_pkg::op_t       cmd_op;
  spq_pkg::status_t   result, result_next;
  logic [CNT_W-1:0]   count, count_next;
  spq_pkg::cell_ctl_t ctl;
  logic               apply_ok;

  spq_pkg::entry_t    held  [DEPTH];
  logic               prefix[DEPTH+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::S_IDLE:    if (start) state_next = spq_pkg::S_COMPARE;
      spq_pkg::S_COMPARE: state_next = spq_pkg::S_APPLY;
      spq_pkg::S_APPLY:   state_next = spq_pkg::S_REPLY;
      spq_pkg::S_REPLY:   state_next = spq_pkg::S_IDLE;
      default:            state_next = spq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    done        = 1'b0;
    ctl.capture = 1'b0;
    ctl.apply   = 1'b0;
    ctl.op      = cmd_op;
    case (state)
      spq_pkg::S_IDLE:    busy = 1'b0;
      spq_pkg::S_COMPARE: ctl.capture = 1'b1;
      spq_pkg::S_APPLY:   ctl.apply = apply_ok;
      spq_pkg::S_REPLY:   done = 1'b1;
      default:            busy = 1'b1;
    endcase
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (state == spq_pkg::S_IDLE && start) begin
      cmd_op    <= spq_pkg::op_t'(operation);
      cmd.valid <= 1'b1;
      cmd.id    <= task_id;
      cmd.prio  <= task_priority;
    end
  end

  // Outcome of the request, decided while the cells shift.
  always_comb begin
    result_next = result;
    count_next  = count;
    apply_ok    = 1'b0;
    if (cmd_op == spq_pkg::OP_INSERT) begin
      if (count == CNT_W'(DEPTH)) begin
        result_next = spq_pkg::ST_FULL;
      end else begin
        result_next = spq_pkg::ST_INSERTED;
        count_next  = count + 1'b1;
        apply_ok    = 1'b1;
      end
    end else begin
      if (count == '0) begin
        result_next = spq_pkg::ST_EMPTY;
      end else if (prefix[DEPTH]) begin
        result_next = spq_pkg::ST_DELETED;
        count_next  = count - 1'b1;
        apply_ok    = 1'b1;
      end else begin
        result_next = spq_pkg::ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == spq_pkg::S_APPLY) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == spq_pkg::S_APPLY) begin
      result <= result_next;
    end
  end

  assign prefix[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_entry, right_entry;
    if (i == 0) begin : g_first
      assign left_entry = '0;
    end else begin : g_mid
      assign left_entry = held[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = held[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .cmd        (cmd),
      .left       (left_entry),
      .right      (right_entry),
      .prefix_in  (prefix[i]),
      .prefix_out (prefix[i+1]),
      .held       (held[i])
    );
  end

  assign status        = result;
  assign entry_count   = spq_pkg::COUNT_W'(count);
  assign head_id       = held[0].valid ? held[0].id   : '0;
  assign head_priority = held[0].valid ? held[0].prio : '0;

endmodule

`default_nettype wire

>>> sv/spq_cell.sv
// One slot of the queue: holds an entry, compares it and shifts with its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire spq_pkg::cell_ctl_t  ctl,
  input  wire spq_pkg::entry_t     cmd,
  input  wire spq_pkg::entry_t     left,
  input  wire spq_pkg::entry_t     right,
  input  wire logic                prefix_in,
  output logic                     prefix_out,
  output spq_pkg::entry_t          held
);

  logic flag;

  // For an insert the flag marks slots that the new task goes ahead of; these form
  // one run at the tail, so the chained prefix equals the flag. For a delete it
  // marks id matches, and the prefix picks out the first match and all after it.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      if (ctl.op == spq_pkg::OP_INSERT) begin
        flag <= !held.valid || ($signed(held.prio) < $signed(cmd.prio));
      end else begin
        flag <= held.valid && (held.id == cmd.id);
      end
    end
  end

  assign prefix_out = prefix_in | flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (ctl.apply) begin
      if (ctl.op == spq_pkg::OP_INSERT) begin
        if (prefix_in) begin
          held <= left;
        end else if (flag) begin
          held <= cmd;
        end
      end else begin
        if (prefix_out) begin
          held <= right;
        end
      end
    end
  end

endmodule

`default_nettype wire
